@@ hw/rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int LOC_W  = 11;
	localparam int DATA_W = 16;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam int TAB_STEP = 8;

	localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0F20;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  char_code;
		logic [3:0]  bg_color;
		logic [3:0]  fg_color;
		logic [10:0] cell_index;
	} tcw_in_t;

	typedef struct packed {
		logic [LOC_W-1:0]  cursor_location;
		logic [DATA_W-1:0] read_data;
		logic              scrolled;
	} tcw_out_t;

	typedef struct packed {
		logic write;
		logic scroll;
	} put_flags_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CLEAR,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} tcw_state_t;

endpackage

@@ hw/rtl/tcw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/tcw_cursor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor registers and put-character decode: next cursor, write position,
// wrap and scroll detection.
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int AW = $clog2(COLUMNS * ROWS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       char_code,
	input  logic             put_en,
	input  logic             home,
	output logic [LOC_W-1:0] cur_loc,
	output logic [LOC_W-1:0] next_loc,
	output logic [AW-1:0]    pos,
	output put_flags_t       flags
);

	localparam int CW  = $clog2(COLUMNS);
	localparam int CXW = CW + 1;
	localparam int RW  = $clog2(ROWS);
	localparam int RXW = RW + 1;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [CXW-1:0] col_x;
	logic [RXW-1:0] row_x;
	logic [CW-1:0]  col_n;
	logic [RW-1:0]  row_n;
	logic [31:0]    cur_full;
	logic [31:0]    next_full;

	always_comb begin
		col_x = CXW'(col_q);
		row_x = RXW'(row_q);
		flags = '0;
		unique case (char_code)
			CH_BS: begin
				if (col_q != '0) begin
					col_x = col_x - CXW'(1);
				end
			end
			CH_TAB: begin
				col_x = (col_x + CXW'(TAB_STEP)) & ~CXW'(TAB_STEP - 1);
			end
			CH_CR: begin
				col_x = '0;
			end
			CH_LF: begin
				col_x = '0;
				row_x = row_x + RXW'(1);
			end
			default: begin
				if (!char_code[7] && (char_code[6:5] != 2'b00)) begin
					flags.write = 1'b1;
					col_x = col_x + CXW'(1);
				end
			end
		endcase
		if (col_x >= CXW'(COLUMNS)) begin
			col_x = '0;
			row_x = row_x + RXW'(1);
		end
		if (row_x >= RXW'(ROWS)) begin
			flags.scroll = 1'b1;
			row_x = RXW'(ROWS - 1);
		end
		col_n = col_x[CW-1:0];
		row_n = row_x[RW-1:0];
	end

	assign cur_full  = 32'(row_q) * 32'(COLUMNS) + 32'(col_q);
	assign next_full = 32'(row_n) * 32'(COLUMNS) + 32'(col_n);
	assign cur_loc   = cur_full[LOC_W-1:0];
	assign next_loc  = next_full[LOC_W-1:0];
	assign pos       = cur_full[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (home) begin
			col_q <= '0;
			row_q <= '0;
		end else if (put_en) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

endmodule

@@ hw/rtl/tcw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: handshakes, screen RAM port control, scroll copy and
// blank fill sweeps, result register.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int AW = $clog2(COLUMNS * ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  tcw_in_t           cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tcw_out_t          rsp,
	input  logic [LOC_W-1:0]  cur_loc,
	input  logic [LOC_W-1:0]  next_loc,
	input  logic [AW-1:0]     pos,
	input  put_flags_t        flags,
	output logic              put_en,
	output logic              home,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [DATA_W-1:0] ram_wdata,
	output logic [AW-1:0]     ram_raddr,
	input  logic [DATA_W-1:0] ram_rdata
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);

	tcw_state_t     state_q;
	tcw_state_t     state_d;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  rdaddr_q;
	tcw_out_t       res_q;
	tcw_out_t       res_d;
	tcw_out_t       out_q;
	tcw_out_t       out_d;
	logic           out_valid_q;
	logic           valid_s1;
	logic [AW-1:0]  waddr_s1;
	logic           out_free;
	logic           acc;
	logic           idx_ok;
	logic [31:0]    idx_full;
	logic [AW-1:0]  cell_addr;
	logic           addr_step;
	logic           addr_clr;
	logic           out_load;
	logic           res_load;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE) || !out_free;
	assign acc       = cmd_valid && !cmd_stall;
	assign idx_full  = 32'(cmd.cell_index);
	assign idx_ok    = idx_full < 32'(CELLS);
	assign cell_addr = idx_full[AW-1:0];
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (addr_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					priority if (cmd.opcode == OP_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (cmd.opcode == OP_PUT && flags.scroll) begin
						state_d = ST_COPY;
					end else if (cmd.opcode == OP_READ && idx_ok) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (addr_q == LAST_CELL) begin
					state_d = ST_DONE;
				end
			end
			ST_COPY: begin
				if (addr_q == COPY_LAST) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (!valid_s1 && addr_q == LAST_CELL) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = BLANK_CELL;
		ram_raddr = rdaddr_q;
		put_en    = 1'b0;
		home      = 1'b0;
		addr_step = 1'b0;
		addr_clr  = 1'b0;
		out_load  = 1'b0;
		out_d     = res_q;
		res_load  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we    = 1'b1;
				addr_step = 1'b1;
			end
			ST_COPY: begin
				ram_raddr = addr_q + AW'(COLUMNS);
				addr_step = 1'b1;
			end
			ST_FILL: begin
				if (!valid_s1) begin
					ram_we    = 1'b1;
					addr_step = 1'b1;
				end
			end
			ST_IDLE: begin
				ram_raddr = cell_addr;
				if (acc) begin
					addr_clr = 1'b1;
					unique case (cmd.opcode)
						OP_PUT: begin
							put_en = 1'b1;
							if (flags.write) begin
								ram_we    = 1'b1;
								ram_waddr = pos;
								ram_wdata = {cmd.bg_color, cmd.fg_color, cmd.char_code};
							end
							if (flags.scroll) begin
								res_load = 1'b1;
								res_d    = '{cursor_location: next_loc, read_data: '0,
									scrolled: 1'b1};
							end else begin
								out_load = 1'b1;
								out_d    = '{cursor_location: next_loc, read_data: '0,
									scrolled: 1'b0};
							end
						end
						OP_CLEAR: begin
							home     = 1'b1;
							res_load = 1'b1;
						end
						OP_READ: begin
							res_d = '{cursor_location: cur_loc, read_data: '0, scrolled: 1'b0};
							if (idx_ok) begin
								res_load = 1'b1;
							end else begin
								out_load = 1'b1;
								out_d    = res_d;
							end
						end
						default: begin
							out_load = 1'b1;
							out_d    = '{cursor_location: cur_loc, read_data: '0,
								scrolled: 1'b0};
						end
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{cursor_location: res_q.cursor_location, read_data: ram_rdata,
						scrolled: 1'b0};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		// trailing write of the scroll copy
		if (valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_COPY);
			if (addr_clr) begin
				addr_q <= '0;
			end else if (addr_step) begin
				addr_q <= addr_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= addr_q;
		if (state_q == ST_IDLE) begin
			rdaddr_q <= cell_addr;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

@@ hw/rtl/text_console_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Character screen of attribute/character cells with a cursor: put
// character, clear and cell read, with wrap and one-line scroll.
// ----------------------------------------------------------------------------
// Results: put without scroll, opcode 3 and out-of-range read give the result
//   in the cycle after the transfer; an in-range read passes the RAM read and ST_READ.
// Throughput: one non-scrolling put per cycle while the result side takes every transfer.
// Scroll and clear each sweep the whole RAM, while cmd_stall stays high.
// Reset: cursor homes and the RAM is swept to blanks, while cmd_stall stays high.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  tcw_in_t  cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output tcw_out_t rsp
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);

	logic [LOC_W-1:0]  cur_loc;
	logic [LOC_W-1:0]  next_loc;
	logic [AW-1:0]     pos;
	put_flags_t        flags;
	logic              put_en;
	logic              home;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	tcw_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_code(cmd.char_code),
		.put_en   (put_en),
		.home     (home),
		.cur_loc  (cur_loc),
		.next_loc (next_loc),
		.pos      (pos),
		.flags    (flags)
	);

	tcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cur_loc  (cur_loc),
		.next_loc (next_loc),
		.pos      (pos),
		.flags    (flags),
		.put_en   (put_en),
		.home     (home),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(ram_waddr) < 32'(CELLS)))
		else $error("screen write outside the cell range");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CELLS > 2048) || (32'(cur_loc) < 32'(CELLS)))
		else $error("cursor outside the screen");

	a_sweep_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && (cmd.opcode == OP_CLEAR ||
			(cmd.opcode == OP_PUT && flags.scroll))) |=> cmd_stall)
		else $error("command taken during a screen sweep");

	a_put_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && cmd.opcode == OP_PUT && flags.write) |-> ram_we)
		else $error("printable character not stored");
`endif

endmodule
